// ===== rtl/xsm_pkg.sv =====
// Shared types, constants and helper functions for the XY spin Metropolis update block.
// Used by every module of the block except xsm_ram; depends on nothing.
package xsm_pkg;

	localparam int LAT_BITS = 6;
	localparam int LAT_SIDE = 1 << LAT_BITS;
	localparam int ADDR_W   = 2 * LAT_BITS;
	localparam int DEPTH    = LAT_SIDE * LAT_SIDE;
	localparam int ANGLE_W  = 16;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [1:0] CFG_MAX_STEP = 2'd0;
	localparam logic [1:0] CFG_COUPLING = 2'd1;
	localparam logic [1:0] CFG_INV_TEMP = 2'd2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [14:0] MAX_STEP_RST = 15'd10430;
	localparam logic [15:0] COUPLING_RST = 16'd4096;
	localparam logic [15:0] INV_TEMP_RST = 16'd256;

	localparam logic signed [30:0] COS_ONE = 31'sd268435456;
	localparam logic signed [30:0] COS_A   = 31'sd331168970;
	localparam logic signed [30:0] COS_B   = 31'sd68093890;
	localparam logic signed [30:0] COS_C   = 31'sd5600498;
	localparam logic signed [MUL_A_W-1:0] COS_D = 34'sd246762;
	localparam logic [14:0] QUARTER = 15'd16384;

	localparam logic signed [MUL_B_W-1:0] LOG2E_Q24 = 26'sd24204406;
	localparam logic signed [MUL_B_W-1:0] LN2_Q24   = 26'sd11629080;
	localparam logic [24:0] Q24_ONE = 25'd16777216;

	typedef struct packed {
		logic              opcode;
		logic [5:0]        site_row;
		logic [5:0]        site_col;
		logic signed [15:0] trial_random;
		logic [15:0]       accept_random;
	} step_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] site_angle;
	} res_t;

	typedef struct packed {
		logic [14:0] max_step;
		logic [15:0] coupling;
		logic [15:0] inverse_temp;
	} cfg_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RDC, ST_OLD, ST_NB_RD, ST_NB_WR,
		ST_TR_MUL, ST_TR_POST, ST_CS_MUL, ST_CS_POST, ST_CS_FIN,
		ST_K_MUL, ST_K_POST, ST_X_MUL, ST_X_POST, ST_Y_MUL, ST_Y_POST,
		ST_G_MUL, ST_G_POST, ST_E_MUL, ST_E_POST, ST_D_MUL, ST_D_POST,
		ST_W, ST_WB, ST_OUT
	} state_t;

	function automatic logic signed [30:0] cos_coef(input logic [2:0] step);
		logic signed [30:0] c;
		unique case (step)
			3'd1:    c = COS_C;
			3'd2:    c = COS_B;
			3'd3:    c = COS_A;
			3'd4:    c = COS_ONE;
			default: c = '0;
		endcase
		return c;
	endfunction

	// floor(2^32 / k) + 1, exact floor division for quotients below 2^25
	function automatic logic signed [MUL_A_W-1:0] div_recip(input logic [2:0] k);
		logic signed [MUL_A_W-1:0] r;
		unique case (k)
			3'd1:    r = 34'sd4294967297;
			3'd2:    r = 34'sd2147483649;
			3'd3:    r = 34'sd1431655766;
			3'd4:    r = 34'sd1073741825;
			3'd5:    r = 34'sd858993460;
			3'd6:    r = 34'sd715827883;
			3'd7:    r = 34'sd613566757;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/xsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module xsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/xsm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on xsm_pkg for operand widths and the request struct.
module xsm_mul (
	input  logic                                clk,
	input  xsm_pkg::mul_req_t                   req,
	output logic signed [xsm_pkg::MUL_P_W-1:0] prod
);

	logic signed [xsm_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= xsm_pkg::MUL_P_W'(req.a) * xsm_pkg::MUL_P_W'(req.b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/xsm_ctrl.sv =====
// Sequencer and datapath registers: lattice clear, neighbor fetch, trial, cosine, energy
// and exponential steps on the shared multiplier. Depends on xsm_pkg.
module xsm_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  xsm_pkg::cfg_t                       cfg,
	input  logic                                step_valid,
	output logic                                step_stall,
	input  xsm_pkg::step_t                      step_data,
	output logic                                res_valid,
	input  logic                                res_stall,
	output xsm_pkg::res_t                       res_data,
	output xsm_pkg::mul_req_t                   mul_req,
	input  logic signed [xsm_pkg::MUL_P_W-1:0] mul_p,
	output logic                                ram_we,
	output logic [xsm_pkg::ADDR_W-1:0]          ram_waddr,
	output logic [15:0]                         ram_wdata,
	output logic [xsm_pkg::ADDR_W-1:0]          ram_raddr,
	input  logic [15:0]                         ram_rdata
);

	xsm_pkg::state_t state_q, state_d;

	logic [xsm_pkg::ADDR_W-1:0] clr_q;
	logic [1:0] nb_cnt_q;
	logic [2:0] ci_q;
	logic [2:0] cstep_q;
	logic [2:0] k_q;

	xsm_pkg::step_t item_q;
	xsm_pkg::res_t  res_q;
	logic [15:0] old_q, trial_q;
	logic [15:0] nb_q [4];
	logic [14:0] z2_q;
	logic signed [30:0] t_q;
	logic signed [18:0] diff_q;
	logic [31:0] kc_q;
	logic [27:0] xs_q;
	logic [4:0]  n_q;
	logic [23:0] f_q, g_q;
	logic [24:0] et_q, m_q;
	logic acc_q;

	logic [xsm_pkg::LAT_BITS-1:0] row, col, rp, rm, cp, cm;
	logic [xsm_pkg::ADDR_W-1:0] center_addr, nb_addr;
	logic [15:0] ang, dang;
	logic [14:0] rr;
	logic cneg;
	logic [29:0] tcl;
	logic [30:0] rnd;
	logic [14:0] cmag;
	logic signed [18:0] cterm;
	logic signed [49:0] x_w;
	logic x_pos, x_big;
	logic [5:0] sh;
	logic [24:0] w;

	assign row = item_q.site_row;
	assign col = item_q.site_col;
	assign rp = (row == xsm_pkg::LAT_BITS'(xsm_pkg::LAT_SIDE - 1)) ? '0 : row + 1'b1;
	assign rm = (row == '0) ? xsm_pkg::LAT_BITS'(xsm_pkg::LAT_SIDE - 1) : row - 1'b1;
	assign cp = (col == xsm_pkg::LAT_BITS'(xsm_pkg::LAT_SIDE - 1)) ? '0 : col + 1'b1;
	assign cm = (col == '0) ? xsm_pkg::LAT_BITS'(xsm_pkg::LAT_SIDE - 1) : col - 1'b1;
	assign center_addr = {row, col};

	always_comb begin
		unique case (nb_cnt_q)
			2'd0: nb_addr = {rp, col};
			2'd1: nb_addr = {rm, col};
			2'd2: nb_addr = {row, cp};
			2'd3: nb_addr = {row, cm};
		endcase
	end

	assign ang  = ci_q[2] ? trial_q : old_q;
	assign dang = ang - nb_q[ci_q[1:0]];
	assign rr   = dang[14] ? (xsm_pkg::QUARTER - {1'b0, dang[13:0]}) : {1'b0, dang[13:0]};
	assign cneg = dang[15] ^ dang[14];
	assign tcl  = t_q[30] ? '0 : t_q[29:0];
	assign rnd  = ({1'b0, tcl} + 31'd8192) >> 14;
	assign cmag = (rnd > 31'd16384) ? xsm_pkg::QUARTER : rnd[14:0];
	always_comb begin
		logic signed [18:0] cv;
		cv = cneg ? -$signed({4'b0, cmag}) : $signed({4'b0, cmag});
		cterm = ci_q[2] ? -cv : cv;
	end

	assign x_w   = mul_p[49:0];
	assign x_pos = !x_w[49] && (x_w != '0);
	assign x_big = |x_w[49:38];
	assign sh    = {1'b0, n_q} + 6'd8;
	assign w     = et_q >> sh;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			xsm_pkg::ST_CLEAR:   if (clr_q == '1) state_d = xsm_pkg::ST_IDLE;
			xsm_pkg::ST_IDLE:    if (step_valid) state_d = xsm_pkg::ST_RDC;
			xsm_pkg::ST_RDC:     state_d = xsm_pkg::ST_OLD;
			xsm_pkg::ST_OLD:     state_d = (item_q.opcode == xsm_pkg::OP_READ) ?
				xsm_pkg::ST_OUT : xsm_pkg::ST_NB_RD;
			xsm_pkg::ST_NB_RD:   state_d = xsm_pkg::ST_NB_WR;
			xsm_pkg::ST_NB_WR:   state_d = (nb_cnt_q == 2'd3) ?
				xsm_pkg::ST_TR_MUL : xsm_pkg::ST_NB_RD;
			xsm_pkg::ST_TR_MUL:  state_d = xsm_pkg::ST_TR_POST;
			xsm_pkg::ST_TR_POST: state_d = xsm_pkg::ST_CS_MUL;
			xsm_pkg::ST_CS_MUL:  state_d = xsm_pkg::ST_CS_POST;
			xsm_pkg::ST_CS_POST: state_d = (cstep_q == 3'd4) ?
				xsm_pkg::ST_CS_FIN : xsm_pkg::ST_CS_MUL;
			xsm_pkg::ST_CS_FIN:  state_d = (ci_q == 3'd7) ?
				xsm_pkg::ST_K_MUL : xsm_pkg::ST_CS_MUL;
			xsm_pkg::ST_K_MUL:   state_d = xsm_pkg::ST_K_POST;
			xsm_pkg::ST_K_POST:  state_d = xsm_pkg::ST_X_MUL;
			xsm_pkg::ST_X_MUL:   state_d = xsm_pkg::ST_X_POST;
			xsm_pkg::ST_X_POST:  state_d = (!x_pos || x_big) ?
				xsm_pkg::ST_WB : xsm_pkg::ST_Y_MUL;
			xsm_pkg::ST_Y_MUL:   state_d = xsm_pkg::ST_Y_POST;
			xsm_pkg::ST_Y_POST:  state_d = xsm_pkg::ST_G_MUL;
			xsm_pkg::ST_G_MUL:   state_d = xsm_pkg::ST_G_POST;
			xsm_pkg::ST_G_POST:  state_d = xsm_pkg::ST_E_MUL;
			xsm_pkg::ST_E_MUL:   state_d = xsm_pkg::ST_E_POST;
			xsm_pkg::ST_E_POST:  state_d = xsm_pkg::ST_D_MUL;
			xsm_pkg::ST_D_MUL:   state_d = xsm_pkg::ST_D_POST;
			xsm_pkg::ST_D_POST:  state_d = (k_q == 3'd1) ? xsm_pkg::ST_W : xsm_pkg::ST_E_MUL;
			xsm_pkg::ST_W:       state_d = xsm_pkg::ST_WB;
			xsm_pkg::ST_WB:      state_d = xsm_pkg::ST_OUT;
			xsm_pkg::ST_OUT:     if (!res_stall) state_d = xsm_pkg::ST_IDLE;
			default:             state_d = xsm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		step_stall = (state_q != xsm_pkg::ST_IDLE);
		res_valid  = (state_q == xsm_pkg::ST_OUT);
		res_data   = res_q;
		ram_we     = (state_q == xsm_pkg::ST_CLEAR) || ((state_q == xsm_pkg::ST_WB) && acc_q);
		ram_waddr  = (state_q == xsm_pkg::ST_CLEAR) ? clr_q : center_addr;
		ram_wdata  = (state_q == xsm_pkg::ST_CLEAR) ? 16'd0 : trial_q;
		ram_raddr  = (state_q == xsm_pkg::ST_NB_RD) ? nb_addr : center_addr;
		mul_req.a  = '0;
		mul_req.b  = '0;
		unique case (state_q)
			xsm_pkg::ST_TR_MUL: begin
				mul_req.a = $signed({19'b0, cfg.max_step});
				mul_req.b = {{10{item_q.trial_random[15]}}, item_q.trial_random};
			end
			xsm_pkg::ST_CS_MUL: begin
				priority case (cstep_q)
					3'd0: begin
						mul_req.a = $signed({19'b0, rr});
						mul_req.b = $signed({11'b0, rr});
					end
					3'd1: begin
						mul_req.a = xsm_pkg::COS_D;
						mul_req.b = $signed({11'b0, z2_q});
					end
					default: begin
						mul_req.a = {{3{t_q[30]}}, t_q};
						mul_req.b = $signed({11'b0, z2_q});
					end
				endcase
			end
			xsm_pkg::ST_K_MUL: begin
				mul_req.a = $signed({18'b0, cfg.coupling});
				mul_req.b = $signed({10'b0, cfg.inverse_temp});
			end
			xsm_pkg::ST_X_MUL: begin
				mul_req.a = $signed({2'b0, kc_q});
				mul_req.b = {{7{diff_q[18]}}, diff_q};
			end
			xsm_pkg::ST_Y_MUL: begin
				mul_req.a = $signed({6'b0, xs_q});
				mul_req.b = xsm_pkg::LOG2E_Q24;
			end
			xsm_pkg::ST_G_MUL: begin
				mul_req.a = $signed({10'b0, f_q});
				mul_req.b = xsm_pkg::LN2_Q24;
			end
			xsm_pkg::ST_E_MUL: begin
				mul_req.a = $signed({10'b0, g_q});
				mul_req.b = $signed({1'b0, et_q});
			end
			xsm_pkg::ST_D_MUL: begin
				mul_req.a = xsm_pkg::div_recip(k_q);
				mul_req.b = $signed({1'b0, m_q});
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= xsm_pkg::ST_CLEAR;
			clr_q    <= '0;
			nb_cnt_q <= '0;
			ci_q     <= '0;
			cstep_q  <= '0;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				xsm_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				xsm_pkg::ST_IDLE: begin
					nb_cnt_q <= '0;
					ci_q     <= '0;
					cstep_q  <= '0;
				end
				xsm_pkg::ST_NB_WR:   nb_cnt_q <= nb_cnt_q + 1'b1;
				xsm_pkg::ST_CS_POST: cstep_q <= cstep_q + 1'b1;
				xsm_pkg::ST_CS_FIN: begin
					cstep_q <= '0;
					ci_q    <= ci_q + 1'b1;
				end
				xsm_pkg::ST_G_POST: k_q <= 3'd7;
				xsm_pkg::ST_D_POST: k_q <= k_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			xsm_pkg::ST_IDLE: begin
				if (step_valid) begin
					item_q <= step_data;
				end
				diff_q <= '0;
			end
			xsm_pkg::ST_OLD: begin
				old_q <= ram_rdata;
				res_q <= '{accepted: 1'b0, site_angle: ram_rdata};
			end
			xsm_pkg::ST_NB_WR:   nb_q[nb_cnt_q] <= ram_rdata;
			xsm_pkg::ST_TR_POST: trial_q <= old_q + mul_p[30:15];
			xsm_pkg::ST_CS_POST: begin
				if (cstep_q == 3'd0) begin
					z2_q <= mul_p[28:14];
				end else begin
					t_q <= xsm_pkg::cos_coef(cstep_q) - mul_p[44:14];
				end
			end
			xsm_pkg::ST_CS_FIN: diff_q <= diff_q + cterm;
			xsm_pkg::ST_K_POST: kc_q <= mul_p[31:0];
			xsm_pkg::ST_X_POST: begin
				acc_q <= !x_pos;
				xs_q  <= x_w[37:10];
			end
			xsm_pkg::ST_Y_POST: begin
				n_q <= mul_p[52:48];
				f_q <= mul_p[47:24];
			end
			xsm_pkg::ST_G_POST: begin
				g_q  <= mul_p[47:24];
				et_q <= xsm_pkg::Q24_ONE;
			end
			xsm_pkg::ST_E_POST: m_q <= mul_p[48:24];
			xsm_pkg::ST_D_POST: et_q <= xsm_pkg::Q24_ONE - mul_p[56:32];
			xsm_pkg::ST_W:      acc_q <= (w > {9'b0, item_q.accept_random});
			xsm_pkg::ST_WB:     res_q <= '{accepted: acc_q, site_angle: acc_q ? trial_q : old_q};
			default: ;
		endcase
	end

endmodule

// ===== rtl/xy_spin_metropolis_update.sv =====
// Top level of the XY spin Metropolis update block: configuration registers and
// the lattice RAM, multiplier and sequencer instances. Depends on xsm_pkg.
//
// Usage:
//   Step channel (step_valid/step_stall/step_data) carries one item: an update of
//   one lattice site or a read of its angle. A transfer happens when step_valid
//   is high and step_stall is low. Result channel (res_valid/res_stall/res_data)
//   returns one result per item: the accept flag and the site angle after it.
//   One item at a time: step_stall stays high from a transfer until its result
//   has been taken; the next transfer comes in the cycle after that at the earliest.
//   A read returns the stored angle without the multiplier; an update runs the
//   exponential test unless the trial is settled by the energy sign or by an
//   energy rise too large for any weight. All steps share one registered
//   multiplier: eight cosines at five products each dominate an update.
//   Reset: control and configuration registers return to their defaults and a
//   clearing pass writes zero to all 4096 lattice entries, one per cycle, with
//   step_stall high throughout. Configuration writes are taken at any time.
//   A stalled result holds on res_data until it is taken.
module xy_spin_metropolis_update (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_valid,
	output logic           step_stall,
	input  xsm_pkg::step_t step_data,
	output logic           res_valid,
	input  logic           res_stall,
	output xsm_pkg::res_t  res_data,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	xsm_pkg::cfg_t cfg_q;
	xsm_pkg::mul_req_t mul_req;
	logic signed [xsm_pkg::MUL_P_W-1:0] mul_p;
	logic ram_we;
	logic [xsm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_step     <= xsm_pkg::MAX_STEP_RST;
			cfg_q.coupling     <= xsm_pkg::COUPLING_RST;
			cfg_q.inverse_temp <= xsm_pkg::INV_TEMP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				xsm_pkg::CFG_MAX_STEP: cfg_q.max_step     <= cfg_data[14:0];
				xsm_pkg::CFG_COUPLING: cfg_q.coupling     <= cfg_data;
				xsm_pkg::CFG_INV_TEMP: cfg_q.inverse_temp <= cfg_data;
				default: ;
			endcase
		end
	end

	xsm_ram #(
		.WIDTH(xsm_pkg::ANGLE_W),
		.DEPTH(xsm_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	xsm_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.prod(mul_p)
	);

	xsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step_valid(step_valid),
		.step_stall(step_stall),
		.step_data (step_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.mul_req   (mul_req),
		.mul_p     (mul_p),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

// ===== rtl/xsm_chk.sv =====
// Port-level checker for the XY spin Metropolis update block, bound to its top level.
// Depends on xsm_pkg for the result struct.
module xsm_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          step_valid,
	input logic          step_stall,
	input logic          res_valid,
	input logic          res_stall,
	input xsm_pkg::res_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_busy_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && !step_stall |=> step_stall)
		else $error("step accepted while previous item in flight");

	a_no_step_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step_stall)
		else $error("step channel open while result pending");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> !res_valid)
		else $error("result repeated after transfer");

endmodule

bind xy_spin_metropolis_update xsm_chk u_xsm_chk (.*);

// ===== sim/xy_spin_metropolis_update_test.sv =====
// Testbench for xy_spin_metropolis_update: directed and random update/read items checked
// against an in-bench lattice predictor. Depends on xsm_pkg and the block RTL only.
module xy_spin_metropolis_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint C_ONE = 268435456;
	localparam longint C_A = 331168970;
	localparam longint C_B = 68093890;
	localparam longint C_C = 5600498;
	localparam longint C_D = 246762;
	localparam longint Q24 = 16777216;
	localparam longint L2E = 24204406;
	localparam longint LN2 = 11629080;

	logic clk, arst_n;
	logic step_valid, step_stall, res_valid, res_stall;
	xsm_pkg::step_t step_data;
	xsm_pkg::res_t res_data;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] lattice [xsm_pkg::DEPTH];
	logic [14:0] max_step_r;
	logic [15:0] coupling_r, inv_temp_r;
	xsm_pkg::res_t expected_results [$];
	int errors = 0;
	int burst_left = 0;

	xy_spin_metropolis_update dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint cos_quarter(input longint r);
		longint z2, t, v;
		z2 = (r * r) >>> 14;
		t = C_C - ((C_D * z2) >>> 14);
		t = C_B - ((t * z2) >>> 14);
		t = C_A - ((t * z2) >>> 14);
		t = C_ONE - ((t * z2) >>> 14);
		if (t < 0) t = 0;
		v = (t + 8192) >>> 14;
		if (v > 16384) v = 16384;
		return v;
	endfunction

	function automatic longint cos_angle(input logic [15:0] a);
		longint r;
		r = longint'(a[13:0]);
		case (a[15:14])
			2'd0: return cos_quarter(r);
			2'd1: return -cos_quarter(16384 - r);
			2'd2: return -cos_quarter(r);
			default: return cos_quarter(16384 - r);
		endcase
	endfunction

	function automatic longint bond_energy(input logic [15:0] c, input logic [5:0] row,
			input logic [5:0] col);
		logic [5:0] rp, rm, cp, cm;
		rp = row + 6'd1;
		rm = row - 6'd1;
		cp = col + 6'd1;
		cm = col - 6'd1;
		return cos_angle(c - lattice[{rp, col}]) + cos_angle(c - lattice[{rm, col}])
			+ cos_angle(c - lattice[{row, cp}]) + cos_angle(c - lattice[{row, cm}]);
	endfunction

	function automatic longint boltzmann_weight(input longint x);
		longint x24, y, f, g, t;
		int n;
		x24 = x >>> 10;
		if (x24 >= 16 * Q24) return 0;
		y = (x24 * L2E) >>> 24;
		n = int'(y >>> 24);
		f = y & (Q24 - 1);
		g = (f * LN2) >>> 24;
		t = Q24;
		for (int k = 7; k >= 1; k--)
			t = Q24 - ((g * t) >>> 24) / k;
		if (t < 0) t = 0;
		if (n + 8 >= 62) return 0;
		return t >>> (n + 8);
	endfunction

	function automatic xsm_pkg::res_t predict_item(input xsm_pkg::step_t s);
		xsm_pkg::res_t r;
		logic [11:0] idx;
		logic [15:0] old, trial;
		longint p, q, x;
		logic acc;
		idx = {s.site_row, s.site_col};
		old = lattice[idx];
		r.accepted = 1'b0;
		r.site_angle = old;
		if (s.opcode == xsm_pkg::OP_READ) return r;
		p = longint'(max_step_r) * longint'(s.trial_random);
		q = (p >= 0) ? (p >>> 15) : -(((-p) + 32767) >>> 15);
		trial = old + 16'(q);
		x = longint'(coupling_r) * longint'(inv_temp_r)
			* (bond_energy(old, s.site_row, s.site_col)
			- bond_energy(trial, s.site_row, s.site_col));
		acc = (x <= 0) || (boltzmann_weight(x) > longint'(s.accept_random));
		if (acc) lattice[idx] = trial;
		r.accepted = acc;
		r.site_angle = lattice[idx];
		return r;
	endfunction

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report("result with nothing pending");
			end else begin
				xsm_pkg::res_t e;
				e = expected_results.pop_front();
				if (res_data.accepted !== e.accepted)
					report($sformatf("accepted %b want %b", res_data.accepted, e.accepted));
				if (res_data.site_angle !== e.site_angle)
					report($sformatf("site_angle %h want %h", res_data.site_angle,
						e.site_angle));
			end
		end
	end

	// receiver stall pattern: free-running, random and heavy stretches
	initial begin
		int mode, left;
		left = 0;
		mode = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(50, 400);
			end
			left--;
			res_stall = (mode == 0) ? 1'b0 : (mode == 1) ? 1'($urandom_range(0, 1))
				: 1'($urandom_range(0, 7) != 0);
		end
	end

	task automatic drop_valid();
		@(negedge clk);
		step_valid = 1'b0;
	endtask

	task automatic send(input xsm_pkg::step_t s);
		int gap;
		@(negedge clk);
		step_valid = 1'b1;
		step_data = s;
		do @(posedge clk); while (step_stall);
		expected_results.insert(expected_results.size(), predict_item(s));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				drop_valid();
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic step_item(input logic op, input logic [5:0] row, input logic [5:0] col,
			input logic [15:0] tr, input logic [15:0] ar);
		xsm_pkg::step_t s;
		s.opcode = op;
		s.site_row = row;
		s.site_col = col;
		s.trial_random = tr;
		s.accept_random = ar;
		send(s);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		drop_valid();
		wait (expected_results.size() == 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (index)
			xsm_pkg::CFG_MAX_STEP: max_step_r = value[14:0];
			xsm_pkg::CFG_COUPLING: coupling_r = value;
			xsm_pkg::CFG_INV_TEMP: inv_temp_r = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [14:0] ms, input logic [15:0] cp,
			input logic [15:0] it);
		write_reg(xsm_pkg::CFG_MAX_STEP, {1'b0, ms});
		write_reg(xsm_pkg::CFG_COUPLING, cp);
		write_reg(xsm_pkg::CFG_INV_TEMP, it);
	endtask

	task automatic test_directed_defaults();
		step_item(xsm_pkg::OP_READ, 6'd0, 6'd0, 16'h0000, 16'h0000);
		step_item(xsm_pkg::OP_READ, 6'd63, 6'd63, 16'hffff, 16'hffff);
		step_item(xsm_pkg::OP_UPDATE, 6'd0, 6'd0, 16'h7fff, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd63, 6'd63, 16'h8000, 16'hffff);
		step_item(xsm_pkg::OP_UPDATE, 6'd0, 6'd63, 16'h0000, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd63, 6'd0, 16'h8000, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd0, 6'd1, 16'h4000, 16'h8000);
		step_item(xsm_pkg::OP_READ, 6'd0, 6'd0, 16'h0000, 16'h0000);
		step_item(xsm_pkg::OP_READ, 6'd63, 6'd63, 16'h0000, 16'h0000);
	endtask

	task automatic test_config_extremes();
		set_config(15'h7fff, 16'hffff, 16'hffff);
		// big energy rise gives a zero weight: reject even with accept_random 0
		step_item(xsm_pkg::OP_UPDATE, 6'd10, 6'd10, 16'h7fff, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd10, 6'd10, 16'h8000, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd0, 6'd0, 16'h8000, 16'h0000);
		step_item(xsm_pkg::OP_UPDATE, 6'd63, 6'd63, 16'h7fff, 16'h0000);
		set_config(15'd0, 16'd0, 16'd0);
		step_item(xsm_pkg::OP_UPDATE, 6'd20, 6'd20, 16'h7fff, 16'hffff);
		step_item(xsm_pkg::OP_UPDATE, 6'd20, 6'd21, 16'h8000, 16'h0000);
		set_config(15'h7fff, 16'd0, 16'hffff);
		step_item(xsm_pkg::OP_UPDATE, 6'd20, 6'd20, 16'h7fff, 16'hffff);
		step_item(xsm_pkg::OP_UPDATE, 6'd20, 6'd21, 16'h1234, 16'hffff);
		set_config(15'h4000, 16'h1000, 16'h0100);
		step_item(xsm_pkg::OP_UPDATE, 6'd20, 6'd22, 16'h7fff, 16'h0001);
		step_item(xsm_pkg::OP_READ, 6'd20, 6'd21, 16'h5555, 16'haaaa);
		drop_valid();
	endtask

	task automatic test_random_phase(input int count);
		logic [5:0] base_r, base_c;
		logic [5:0] row, col;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				base_r = 6'($urandom);
				base_c = 6'($urandom);
			end
			if ($urandom_range(0, 3) == 0) begin
				row = 6'($urandom);
				col = 6'($urandom);
			end else begin
				row = base_r + 6'($urandom_range(0, 3));
				col = base_c + 6'($urandom_range(0, 3));
			end
			step_item(($urandom_range(0, 9) == 0) ? xsm_pkg::OP_READ : xsm_pkg::OP_UPDATE,
				row, col, 16'($urandom), 16'($urandom));
		end
		drop_valid();
	endtask

	task automatic test_random_configs();
		set_config(15'd10430, 16'd4096, 16'd256);
		test_random_phase(470);
		set_config(15'($urandom), 16'($urandom_range(256, 8192)), 16'($urandom_range(16, 1024)));
		test_random_phase(470);
		set_config(15'h7fff, 16'd512, 16'd64);
		test_random_phase(470);
		set_config(15'($urandom_range(0, 2000)), 16'($urandom), 16'($urandom));
		test_random_phase(470);
	endtask

	initial begin
		arst_n = 1'b0;
		step_valid = 1'b0;
		step_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = xsm_pkg::CFG_MAX_STEP;
		cfg_data = '0;
		max_step_r = 15'd10430;
		coupling_r = 16'd4096;
		inv_temp_r = 16'd256;
		for (int i = 0; i < xsm_pkg::DEPTH; i++) lattice[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_defaults();
		test_config_extremes();
		test_random_configs();
		wait (expected_results.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ===== xy_spin_metropolis_update.f =====
rtl/xsm_pkg.sv
rtl/xsm_ram.sv
rtl/xsm_mul.sv
rtl/xsm_ctrl.sv
rtl/xy_spin_metropolis_update.sv
rtl/xsm_chk.sv
sim/xy_spin_metropolis_update_test.sv
